// ----- sv/brp_pkg.sv -----
`default_nettype none
package brp_pkg;

    // Ring geometry and field limits
    localparam int RING_BITS = 64;
    localparam int PTR_W     = $clog2(RING_BITS);
    localparam int MAX_FIELD = 32;
    localparam int N_W       = $clog2(MAX_FIELD + 1);

    // Fixed item field widths
    localparam int OP_W      = 2;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 6;
    localparam int HELD_W    = 6;
    localparam int SH_W      = $clog2(VALUE_W + 1);

    // Stream payload widths, padded to whole bytes
    localparam int S_DATA_RAW = OP_W + VALUE_W + COUNT_W;
    localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;
    localparam int M_DATA_RAW = 2 * VALUE_W + HELD_W + 1;
    localparam int M_DATA_W   = ((M_DATA_RAW + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_MSB = 2'd0,
        OP_PUSH_LSB = 2'd1,
        OP_POP_LSB  = 2'd2,
        OP_POP_MSB  = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // latch the accepted item
        logic execute;  // apply the latched item to the ring
    } brp_cmd_t;

    function automatic logic [VALUE_W-1:0] rev_bits(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] r;
        for (int i = 0; i < VALUE_W; i++) begin
            r[i] = v[VALUE_W-1-i];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/brp_ctrl.sv -----
`default_nettype none
module brp_ctrl
    import brp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output brp_cmd_t      cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // wait until the previous result has left the output
                if (!out_valid_reg || m_tready) begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

// ----- sv/brp_datapath.sv -----
`default_nettype none
module brp_datapath
    import brp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire brp_cmd_t            cmd,
    input  wire logic [OP_W-1:0]     op_in,
    input  wire logic [VALUE_W-1:0]  value_in,
    input  wire logic [COUNT_W-1:0]  count_in,
    output logic [VALUE_W-1:0]       popped_value,
    output logic [VALUE_W-1:0]       previous_value,
    output logic [HELD_W-1:0]        bits_held,
    output logic                     fault
);

    op_t                  op_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [COUNT_W-1:0]   count_reg;

    logic [RING_BITS-1:0] store_reg, store_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [VALUE_W-1:0]   cur_pop_reg, cur_pop_next;
    logic [VALUE_W-1:0]   prior_pop_reg, prior_pop_next;
    logic                 fault_reg, fault_next;

    logic [N_W-1:0]       n;
    logic [SH_W-1:0]      rsh;
    logic [VALUE_W-1:0]   field_mask;
    logic [VALUE_W-1:0]   push_bits;
    logic [VALUE_W-1:0]   pop_raw;
    logic [VALUE_W-1:0]   pop_bits;
    logic [RING_BITS-1:0] ring_mask;
    logic [RING_BITS-1:0] ring_data;
    logic [RING_BITS-1:0] ring_view;
    logic [PTR_W-1:0]     held;
    logic                 is_push;

    function automatic logic [RING_BITS-1:0] rotl(input logic [RING_BITS-1:0] x,
                                                  input logic [PTR_W-1:0] s);
        logic [2*RING_BITS-1:0] t;
        t = {x, x} << s;
        return t[2*RING_BITS-1:RING_BITS];
    endfunction

    function automatic logic [RING_BITS-1:0] rotr(input logic [RING_BITS-1:0] x,
                                                  input logic [PTR_W-1:0] s);
        logic [2*RING_BITS-1:0] t;
        t = {x, x} >> s;
        return t[RING_BITS-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [N_W-1:0] k);
        logic [PTR_W+N_W:0] s;
        s = (PTR_W+N_W+1)'(p) + (PTR_W+N_W+1)'(k);
        if (s >= (PTR_W+N_W+1)'(RING_BITS)) begin
            s = s - (PTR_W+N_W+1)'(RING_BITS);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_diff(input logic [PTR_W-1:0] w,
                                                  input logic [PTR_W-1:0] r);
        logic [PTR_W:0] d;
        if (w >= r) begin
            d = {1'b0, w} - {1'b0, r};
        end else begin
            d = {1'b0, w} + (PTR_W+1)'(RING_BITS) - {1'b0, r};
        end
        return d[PTR_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= op_t'(op_in);
            value_reg <= value_in;
            count_reg <= count_in;
        end
        fault_reg <= fault_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg     <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            cur_pop_reg   <= '0;
            prior_pop_reg <= '0;
        end else begin
            store_reg     <= store_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            cur_pop_reg   <= cur_pop_next;
            prior_pop_reg <= prior_pop_next;
        end
    end

    always_comb begin
        // saturate the field length
        n = (count_reg > COUNT_W'(MAX_FIELD)) ? N_W'(MAX_FIELD) : N_W'(count_reg);
        rsh        = SH_W'(VALUE_W) - SH_W'(n);
        field_mask = {VALUE_W{1'b1}} >> rsh;
        if (n == '0) begin
            field_mask = '0;
        end
        is_push = (op_reg == OP_PUSH_MSB) || (op_reg == OP_PUSH_LSB);
        held    = ptr_diff(wr_ptr_reg, rd_ptr_reg);

        // push: line the field up so that its first bit sits at bit 0
        if (op_reg == OP_PUSH_MSB) begin
            push_bits = rev_bits(value_reg) >> rsh;
        end else begin
            push_bits = value_reg & field_mask;
        end
        ring_mask = rotl(RING_BITS'(field_mask), wr_ptr_reg);
        ring_data = rotl(RING_BITS'(push_bits), wr_ptr_reg);

        // pop: bring the read pointer to bit 0, first bit lands at the LSB
        ring_view = rotr(store_reg, rd_ptr_reg);
        pop_raw   = ring_view[VALUE_W-1:0] & field_mask;
        if (op_reg == OP_POP_MSB) begin
            pop_bits = rev_bits(pop_raw) >> rsh;
        end else begin
            pop_bits = pop_raw;
        end

        store_next     = store_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        cur_pop_next   = cur_pop_reg;
        prior_pop_next = prior_pop_reg;
        fault_next     = fault_reg;
        if (cmd.execute) begin
            if (is_push) begin
                store_next  = (store_reg & ~ring_mask) | ring_data;
                wr_ptr_next = ptr_add(wr_ptr_reg, n);
                fault_next  = ((PTR_W+N_W+1)'(held) + (PTR_W+N_W+1)'(n))
                              >= (PTR_W+N_W+1)'(RING_BITS);
            end else begin
                rd_ptr_next    = ptr_add(rd_ptr_reg, n);
                prior_pop_next = cur_pop_reg;
                cur_pop_next   = pop_bits;
                fault_next     = (PTR_W+N_W+1)'(n) > (PTR_W+N_W+1)'(held);
            end
        end
    end

    // the state only moves when the previous result has been taken
    assign popped_value   = cur_pop_reg;
    assign previous_value = prior_pop_reg;
    assign bits_held      = HELD_W'(ptr_diff(wr_ptr_reg, rd_ptr_reg));
    assign fault          = fault_reg;

endmodule
`default_nettype wire

// ----- sv/bit_ring_packer_core.sv -----
`default_nettype none
// Circular bit FIFO of RING_BITS cells with variable-width push and pop. Each
// item carries an op, a value and a count (saturated to MAX_FIELD). Pushes
// append the low count bits msb-first or lsb-first; pops remove count bits and
// assemble them with the first bit at the LSB or at the MSB of the field, and
// report the pop value that was held before. Every item gives one result with
// the current pop value, the previous pop value, the bit occupancy and a fault
// flag for overflow or underflow (the ring still wraps and overwrites or
// rereads). An item is latched in ST_IDLE and applied in ST_EXEC by barrel
// rotations of the ring, so a new item is not accepted until the last one has
// been applied. The result sits in the output register and the next item is
// latched while it waits; execution of that item holds until the result has
// been taken. No clearing pass follows reset.
module bit_ring_packer_core
    import brp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // s_tdata: op [1:0], value [33:2], count [39:34]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // m_tdata: popped_value [31:0], previous_value [63:32], bits_held [69:64],
    //          fault [70], zero pad [71]
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready
);

    brp_cmd_t            cmd;
    logic [VALUE_W-1:0]  popped_value;
    logic [VALUE_W-1:0]  previous_value;
    logic [HELD_W-1:0]   bits_held;
    logic                fault;

    // Sequence capture, execute and output handoff
    brp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Ring storage, pointers and pop registers
    brp_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .op_in          (s_tdata[OP_W-1:0]),
        .value_in       (s_tdata[OP_W+VALUE_W-1:OP_W]),
        .count_in       (s_tdata[OP_W+VALUE_W+COUNT_W-1:OP_W+VALUE_W]),
        .popped_value   (popped_value),
        .previous_value (previous_value),
        .bits_held      (bits_held),
        .fault          (fault)
    );

    // Pack the result, zero pad to whole bytes
    assign m_tdata = M_DATA_W'({fault, bits_held, previous_value, popped_value});

endmodule
`default_nettype wire

// ----- sim/tb_bit_ring_packer_core.sv -----
`timescale 1ns / 100ps
// Drives push and pop items into the bit ring packer and checks every result against a
// behavioral copy of the 64-bit ring kept in the bench.
module tb_bit_ring_packer_core;
    import brp_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int TAIL_ITEMS   = 100;      // last items run with no idling on either side
    localparam int SETTLE_WAIT  = 16;       // settling wait after the last result
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        op_t               op;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        bit                drain_first;     // hold this item until no result is outstanding
    } ring_item_t;

    typedef struct {
        logic [VALUE_W-1:0] popped;
        logic [VALUE_W-1:0] previous;
        logic [HELD_W-1:0]  held;
        logic               fault;
    } ring_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    bit_ring_packer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Bench copy of the ring
    logic [RING_BITS-1:0] ring_cells;
    logic [PTR_W-1:0]     rd_ptr;
    logic [PTR_W-1:0]     wr_ptr;
    logic [VALUE_W-1:0]   pop_now;
    logic [VALUE_W-1:0]   pop_before;

    ring_item_t   pending_items[$];
    ring_result_t expected_results[$];
    ring_item_t   next_item;
    int           items_queued   = 0;
    int           items_accepted = 0;
    int           error_count    = 0;
    int           cycle_count    = 0;
    int           send_gap       = 0;
    int           take_stall     = 0;
    int           fill_level     = 0;   // occupancy the generator believes the ring holds
    bit           s_accepted     = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Apply one item to the bench ring and return the result it should produce.
    task automatic step_ring_model(input op_t op, input logic [VALUE_W-1:0] value,
                                   input logic [COUNT_W-1:0] count,
                                   output ring_result_t res);
        int               n;
        int               sh;
        logic [PTR_W-1:0] held_now;
        logic [VALUE_W-1:0] acc;
        n        = (count > MAX_FIELD) ? MAX_FIELD : int'(count);
        held_now = wr_ptr - rd_ptr;
        res.fault = 1'b0;
        if (op == OP_PUSH_MSB || op == OP_PUSH_LSB) begin
            if (int'(held_now) + n >= RING_BITS) res.fault = 1'b1;
            for (int j = 0; j < n; j++) begin
                sh = (op == OP_PUSH_MSB) ? (n - 1 - j) : j;
                ring_cells[wr_ptr] = value[sh];
                wr_ptr = wr_ptr + 1'b1;
            end
        end else begin
            if (n > int'(held_now)) res.fault = 1'b1;
            pop_before = pop_now;
            acc = '0;
            for (int j = 0; j < n; j++) begin
                sh = (op == OP_POP_LSB) ? j : (n - 1 - j);
                acc[sh] = ring_cells[rd_ptr];
                rd_ptr = rd_ptr + 1'b1;
            end
            pop_now = acc;
        end
        res.popped   = pop_now;
        res.previous = pop_before;
        res.held     = HELD_W'(wr_ptr - rd_ptr);
    endtask

    // Queue an item and track the occupancy it leaves, wrapping as the ring does.
    task automatic queue_item(input op_t op, input logic [VALUE_W-1:0] value,
                              input int count, input bit drain_first = 1'b0);
        ring_item_t it;
        int         n;
        it.op          = op;
        it.value       = value;
        it.count       = COUNT_W'(count);
        it.drain_first = drain_first;
        pending_items.push_back(it);
        items_queued++;
        n = (count > MAX_FIELD) ? MAX_FIELD : count;
        if (op == OP_PUSH_MSB || op == OP_PUSH_LSB) begin
            fill_level = (fill_level + n) % RING_BITS;
        end else begin
            fill_level = (fill_level + RING_BITS - n) % RING_BITS;
        end
    endtask

    function automatic bit idle_roll(input int mode);
        case (mode)
            0: return 1'b0;
            1: return $urandom_range(0, 7) == 0;
            default: return $urandom_range(0, 2) == 0;
        endcase
    endfunction

    // Monitor: sample both channels at the rising edge.
    always @(posedge aclk) begin
        ring_result_t exp_res;
        ring_result_t got;
        s_accepted = aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got.popped   = m_tdata[VALUE_W-1:0];
            got.previous = m_tdata[2*VALUE_W-1:VALUE_W];
            got.held     = m_tdata[2*VALUE_W+HELD_W-1:2*VALUE_W];
            got.fault    = m_tdata[2*VALUE_W+HELD_W];
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding, tdata %h", m_tdata));
            end else begin
                exp_res = expected_results.pop_front();
                if (got.popped !== exp_res.popped)
                    report_mismatch($sformatf("popped_value %h, want %h",
                                              got.popped, exp_res.popped));
                if (got.previous !== exp_res.previous)
                    report_mismatch($sformatf("previous_value %h, want %h",
                                              got.previous, exp_res.previous));
                if (got.held !== exp_res.held)
                    report_mismatch($sformatf("bits_held %0d, want %0d",
                                              got.held, exp_res.held));
                if (got.fault !== exp_res.fault)
                    report_mismatch($sformatf("fault %b, want %b",
                                              got.fault, exp_res.fault));
            end
        end
        if (s_accepted) begin
            step_ring_model(op_t'(s_tdata[OP_W-1:0]), s_tdata[OP_W+VALUE_W-1:OP_W],
                            s_tdata[OP_W+VALUE_W+COUNT_W-1:OP_W+VALUE_W], exp_res);
            expected_results.push_back(exp_res);
            items_accepted++;
        end
    end

    // Driver: advance to the next item at the falling edge once the current one is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_accepted) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain_first && expected_results.size() != 0)) begin
                next_item = pending_items.pop_front();
                s_tdata  <= S_DATA_W'({next_item.count, next_item.value, next_item.op});
                s_tvalid <= 1'b1;
                if (pending_items.size() >= TAIL_ITEMS &&
                    idle_roll((items_accepted / 96) % 3))
                    send_gap = $urandom_range(1, 10);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall in bursts, drop the stalls in the tail.
    always @(negedge aclk) begin
        if (take_stall > 0) begin
            take_stall = take_stall - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (aresetn && pending_items.size() >= TAIL_ITEMS &&
                idle_roll((items_accepted / 80 + 1) % 3))
                take_stall = $urandom_range(1, 10);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_bit_ring_packer_core: done, errors");
            $finish;
        end
    end

    initial begin
        int  n;
        int  room;
        op_t op;
        logic [VALUE_W-1:0] value;

        ring_cells = '0;
        rd_ptr     = '0;
        wr_ptr     = '0;
        pop_now    = '0;
        pop_before = '0;

        // Directed: zero counts, both push orders, both pop orders, saturation,
        // overflow, underflow and field extremes.
        queue_item(OP_POP_LSB,  32'h0000_0000, 0);
        queue_item(OP_PUSH_MSB, 32'hFFFF_FFFF, 0);
        queue_item(OP_PUSH_MSB, 32'h0000_00A5, 8);
        queue_item(OP_PUSH_LSB, 32'h0000_003C, 8);
        queue_item(OP_POP_MSB,  32'hFFFF_FFFF, 8);
        queue_item(OP_POP_LSB,  32'h0000_0000, 8);
        queue_item(OP_PUSH_MSB, 32'hFFFF_FFFF, 32);
        queue_item(OP_PUSH_LSB, 32'h1234_5678, 63);
        queue_item(OP_POP_LSB,  32'h0000_0000, 32);
        queue_item(OP_POP_MSB,  32'h0000_0000, 40);
        queue_item(OP_PUSH_MSB, 32'h0000_0000, 1);
        queue_item(OP_PUSH_LSB, 32'h0000_0001, 1);
        queue_item(OP_POP_MSB,  32'h0000_0000, 2, 1'b1);
        queue_item(OP_PUSH_LSB, 32'h8000_0001, 32);
        queue_item(OP_PUSH_MSB, 32'hDEAD_BEEF, 31);
        queue_item(OP_POP_MSB,  32'h0000_0000, 32);
        queue_item(OP_POP_LSB,  32'h0000_0000, 31);
        queue_item(OP_POP_LSB,  32'h0000_0000, 33);
        queue_item(OP_PUSH_LSB, 32'h0000_0000, 32);
        queue_item(OP_POP_MSB,  32'hFFFF_FFFF, 63);
        queue_item(OP_PUSH_MSB, 32'h5555_AAAA, 16);
        queue_item(OP_POP_LSB,  32'h0000_0000, 1);

        // Random: mostly legal traffic that keeps the ring between empty and full,
        // with some counts anywhere in the field and wrap-causing items mixed in.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 7))
                0:       value = '0;
                1:       value = '1;
                default: value = $urandom;
            endcase
            if ($urandom_range(0, 9) == 0) begin
                op = op_t'($urandom_range(0, 3));
                n  = $urandom_range(0, 63);
            end else begin
                if (fill_level < 16)      op = ($urandom_range(0, 3) != 0) ? OP_PUSH_MSB : OP_POP_LSB;
                else if (fill_level > 48) op = ($urandom_range(0, 3) != 0) ? OP_POP_MSB : OP_PUSH_LSB;
                else                      op = op_t'($urandom_range(0, 3));
                if (op == OP_PUSH_MSB || op == OP_PUSH_LSB) begin
                    if ($urandom_range(0, 1) == 0) op = ($urandom_range(0, 1) == 0) ? OP_PUSH_MSB : OP_PUSH_LSB;
                    room = RING_BITS - 1 - fill_level;
                end else begin
                    if ($urandom_range(0, 1) == 0) op = ($urandom_range(0, 1) == 0) ? OP_POP_LSB : OP_POP_MSB;
                    room = fill_level;
                end
                n = $urandom_range(0, (room > MAX_FIELD) ? MAX_FIELD : room);
            end
            queue_item(op, value, n, (i % 150) == 75);
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (items_accepted < items_queued || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);

        if (error_count == 0) begin
            $display("tb_bit_ring_packer_core: done, clean");
        end else begin
            $display("tb_bit_ring_packer_core: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/brp_pkg.sv
sv/brp_ctrl.sv
sv/brp_datapath.sv
sv/bit_ring_packer_core.sv
sim/tb_bit_ring_packer_core.sv
